/* rtl/bcae_pkg.sv */
package bcae_pkg;

   typedef enum logic [1:0] {
      MODE_LOAD,
      MODE_PLAN,
      MODE_PASS,
      MODE_EMIT
   } mode_type;

   typedef enum logic [1:0] {
      OP_LOCAL,
      OP_SHIFT,
      OP_UNSHIFT
   } op_type;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RULE_TABLE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_ODD   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GEN_COUNT   = 3'd4;

   localparam int TILE_W = 64;
   localparam int GEN_W = 16;
   localparam logic [2:0] STEP_LAST = 3'd5;

   // move every cell one down and one right, pulling from the tiles above and left
   function automatic logic [TILE_W-1:0] shift_down_right(input logic [TILE_W-1:0] own,
                                                          input logic [TILE_W-1:0] vert,
                                                          input logic [TILE_W-1:0] horiz,
                                                          input logic [TILE_W-1:0] diag);
      logic [TILE_W-1:0] t;
      t = '0;
      for (int y = 0; y < 8; y++) begin
         for (int x = 0; x < 8; x++) begin
            if (y > 0 && x > 0) begin
               t[y*8+x] = own[(y-1)*8+x-1];
            end else if (y == 0 && x > 0) begin
               t[x] = vert[56+x-1];
            end else if (y > 0 && x == 0) begin
               t[y*8] = horiz[(y-1)*8+7];
            end else begin
               t[0] = diag[63];
            end
         end
      end
      return t;
   endfunction

   // move every cell one up and one left, pulling from the tiles below and right
   function automatic logic [TILE_W-1:0] shift_up_left(input logic [TILE_W-1:0] own,
                                                       input logic [TILE_W-1:0] vert,
                                                       input logic [TILE_W-1:0] horiz,
                                                       input logic [TILE_W-1:0] diag);
      logic [TILE_W-1:0] t;
      t = '0;
      for (int y = 0; y < 8; y++) begin
         for (int x = 0; x < 8; x++) begin
            if (y < 7 && x < 7) begin
               t[y*8+x] = own[(y+1)*8+x+1];
            end else if (y == 7 && x < 7) begin
               t[56+x] = vert[x+1];
            end else if (y < 7 && x == 7) begin
               t[y*8+7] = horiz[(y+1)*8];
            end else begin
               t[63] = diag[0];
            end
         end
      end
      return t;
   endfunction

   // replace each even-aligned 2x2 block through the rule table
   function automatic logic [TILE_W-1:0] apply_rule(input logic [TILE_W-1:0] t,
                                                    input logic [TILE_W-1:0] rule);
      logic [TILE_W-1:0] o;
      logic [3:0] idx;
      logic [3:0] res;
      int b;
      o = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            b = 16*r + 2*c;
            idx = {t[b+9], t[b+8], t[b+1], t[b]};
            res = rule[idx*4 +: 4];
            o[b]   = res[0];
            o[b+1] = res[1];
            o[b+8] = res[2];
            o[b+9] = res[3];
         end
      end
      return o;
   endfunction

endpackage

/* rtl/block_cellular_automaton_engine_top.sv */
// Margolus block cellular automaton engine.
// req channel: one 8x8 tile per item in row-major tile order; the item with
// req_tile_in_last set starts the run. Tiles beyond width*height are dropped.
// rsp channel: after the run, all width*height tiles in the same order, the
// final one with rsp_tile_out_last set.
// csr port: write-only registers, rule table, grid width/height, first phase
// and generation count; write them only while the engine is idle.
// Loading takes one tile per cycle. Each generation is one pass over the tile
// memory: per tile, four single-port reads of the tile and its neighbors, each
// read registered, then one write; a PLAN state runs before every pass.
// Odd-aligned generations are done by moving the grid one cell diagonally, so
// up to two extra passes (realign and copy home) may follow the last one.
// Result reads do not overlap: the next is issued only once the last one has
// left the memory read register for the single output register. A stalled
// rsp holds its tile and stops further reads; req_stall stays high from the
// last tile until the last result read is issued. Reset returns to loading
// with registers at defaults; the tile memories are not cleared.
module block_cellular_automaton_engine_top #(
   parameter int MAX_WIDTH_TILES  = 8,
   parameter int MAX_HEIGHT_TILES = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [bcae_pkg::TILE_W-1:0]              req_tile_in,
   input  logic                                     req_tile_in_last,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [bcae_pkg::TILE_W-1:0]              rsp_tile_out,
   output logic                                     rsp_tile_out_last,
   input  logic                                     csr_write,
   input  logic [bcae_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [bcae_pkg::TILE_W-1:0]              csr_data
);

   localparam int DEPTH = MAX_WIDTH_TILES * MAX_HEIGHT_TILES;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);
   localparam int RW = (MAX_HEIGHT_TILES > 1) ? $clog2(MAX_HEIGHT_TILES) : 1;
   localparam int CW = (MAX_WIDTH_TILES > 1) ? $clog2(MAX_WIDTH_TILES) : 1;
   localparam int WD = $clog2(MAX_WIDTH_TILES + 1);
   localparam int HD = $clog2(MAX_HEIGHT_TILES + 1);
   localparam int PW = RW + WD;

   logic [bcae_pkg::TILE_W-1:0] rule_ff;
   logic [3:0]                  width_ff;
   logic [3:0]                  height_ff;
   logic                        first_odd_ff;
   logic [bcae_pkg::GEN_W-1:0]  gen_count_ff;

   bcae_pkg::mode_type mode_ff, mode_in;
   bcae_pkg::op_type   op_ff, op_in;
   logic [NW-1:0] loaded_ff, loaded_in;
   logic [bcae_pkg::GEN_W-1:0] gens_ff, gens_in;
   logic phase_ff, phase_in;
   logic frame_ff, frame_in;
   logic src_ff, src_in;
   logic rule_on_ff, rule_on_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [2:0] step_ff, step_in;
   logic [NW-1:0] emit_ff, emit_in;
   logic pend_ff, pend_in;
   logic pend_last_ff, pend_last_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [bcae_pkg::TILE_W-1:0] rsp_tile_ff;
   logic rsp_last_ff;
   logic [bcae_pkg::TILE_W-1:0] nb_ff [4];

   logic [bcae_pkg::TILE_W-1:0] mem_a [DEPTH];
   logic [bcae_pkg::TILE_W-1:0] mem_b [DEPTH];
   logic [bcae_pkg::TILE_W-1:0] rda_ff;
   logic [bcae_pkg::TILE_W-1:0] rdb_ff;

   logic [WD-1:0] w_eff;
   logic [HD-1:0] h_eff;
   logic [NW-1:0] n_tiles;
   logic [NW-1:0] n_last;
   logic [RW-1:0] row_max, row_up, row_dn, vrow, rd_row;
   logic [CW-1:0] col_max, col_lf, col_rt, hcol, rd_col;
   logic [PW-1:0] pass_mul, own_mul;
   logic [AW-1:0] pass_addr, own_addr, rd_addr, wa_addr;
   logic [bcae_pkg::TILE_W-1:0] assembled, new_tile, wa_data;
   logic load_we, pass_we, emit_rd, wa_en, wb_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff      <= '0;
         width_ff     <= 4'd8;
         height_ff    <= 4'd8;
         first_odd_ff <= 1'b0;
         gen_count_ff <= 16'd1;
      end else if (csr_write) begin
         case (csr_index)
            bcae_pkg::CSR_RULE_TABLE:  rule_ff      <= csr_data;
            bcae_pkg::CSR_GRID_WIDTH:  width_ff     <= csr_data[3:0];
            bcae_pkg::CSR_GRID_HEIGHT: height_ff    <= csr_data[3:0];
            bcae_pkg::CSR_FIRST_ODD:   first_odd_ff <= csr_data[0];
            bcae_pkg::CSR_GEN_COUNT:   gen_count_ff <= csr_data[bcae_pkg::GEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == 4'd0) begin
         w_eff = WD'(1);
      end else if (int'(width_ff) > MAX_WIDTH_TILES) begin
         w_eff = WD'(MAX_WIDTH_TILES);
      end else begin
         w_eff = WD'(width_ff);
      end
      if (height_ff == 4'd0) begin
         h_eff = HD'(1);
      end else if (int'(height_ff) > MAX_HEIGHT_TILES) begin
         h_eff = HD'(MAX_HEIGHT_TILES);
      end else begin
         h_eff = HD'(height_ff);
      end
   end

   assign n_tiles = NW'((WD+HD)'(w_eff) * (WD+HD)'(h_eff));
   assign n_last  = NW'(n_tiles - NW'(1));
   assign row_max = RW'(h_eff - HD'(1));
   assign col_max = CW'(w_eff - WD'(1));

   // toroidal neighbors of the current tile
   assign row_up = (row_ff == '0) ? row_max : RW'(row_ff - RW'(1));
   assign row_dn = (row_ff == row_max) ? '0 : RW'(row_ff + RW'(1));
   assign col_lf = (col_ff == '0) ? col_max : CW'(col_ff - CW'(1));
   assign col_rt = (col_ff == col_max) ? '0 : CW'(col_ff + CW'(1));
   assign vrow   = (op_ff == bcae_pkg::OP_UNSHIFT) ? row_dn : row_up;
   assign hcol   = (op_ff == bcae_pkg::OP_UNSHIFT) ? col_rt : col_lf;

   always_comb begin
      rd_row = row_ff;
      rd_col = col_ff;
      if (op_ff != bcae_pkg::OP_LOCAL) begin
         case (step_ff)
            3'd1: begin
               rd_row = vrow;
            end
            3'd2: begin
               rd_col = hcol;
            end
            3'd3: begin
               rd_row = vrow;
               rd_col = hcol;
            end
            default: ;
         endcase
      end
   end

   assign pass_mul  = PW'(rd_row) * PW'(w_eff);
   assign pass_addr = AW'(pass_mul + PW'(rd_col));
   assign own_mul   = PW'(row_ff) * PW'(w_eff);
   assign own_addr  = AW'(own_mul + PW'(col_ff));

   always_comb begin
      case (op_ff)
         bcae_pkg::OP_SHIFT:
            assembled = bcae_pkg::shift_down_right(nb_ff[0], nb_ff[1], nb_ff[2], nb_ff[3]);
         bcae_pkg::OP_UNSHIFT:
            assembled = bcae_pkg::shift_up_left(nb_ff[0], nb_ff[1], nb_ff[2], nb_ff[3]);
         default:
            assembled = nb_ff[0];
      endcase
      new_tile = rule_on_ff ? bcae_pkg::apply_rule(assembled, rule_ff) : assembled;
   end

   always_comb begin
      mode_in      = mode_ff;
      op_in        = op_ff;
      loaded_in    = loaded_ff;
      gens_in      = gens_ff;
      phase_in     = phase_ff;
      frame_in     = frame_ff;
      src_in       = src_ff;
      rule_on_in   = rule_on_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      step_in      = step_ff;
      emit_in      = emit_ff;
      load_we      = 1'b0;
      pass_we      = 1'b0;
      emit_rd      = 1'b0;
      case (mode_ff)
         bcae_pkg::MODE_LOAD: begin
            if (req_valid) begin
               if (loaded_ff < n_tiles) begin
                  load_we   = 1'b1;
                  loaded_in = NW'(loaded_ff + NW'(1));
               end
               if (req_tile_in_last) begin
                  mode_in  = bcae_pkg::MODE_PLAN;
                  gens_in  = gen_count_ff;
                  phase_in = first_odd_ff;
               end
            end
         end
         bcae_pkg::MODE_PLAN: begin
            row_in  = '0;
            col_in  = '0;
            step_in = '0;
            mode_in = bcae_pkg::MODE_PASS;
            if (gens_ff != '0) begin
               rule_on_in = 1'b1;
               if (phase_ff == frame_ff) begin
                  op_in = bcae_pkg::OP_LOCAL;
               end else if (!frame_ff) begin
                  op_in = bcae_pkg::OP_SHIFT;
               end else begin
                  op_in = bcae_pkg::OP_UNSHIFT;
               end
            end else if (frame_ff) begin
               rule_on_in = 1'b0;
               op_in      = bcae_pkg::OP_UNSHIFT;
            end else if (src_ff) begin
               rule_on_in = 1'b0;
               op_in      = bcae_pkg::OP_LOCAL;
            end else begin
               mode_in = bcae_pkg::MODE_EMIT;
               emit_in = '0;
            end
         end
         bcae_pkg::MODE_PASS: begin
            if (step_ff != bcae_pkg::STEP_LAST) begin
               step_in = 3'(step_ff + 3'd1);
            end else begin
               pass_we = 1'b1;
               step_in = '0;
               if (col_ff != col_max) begin
                  col_in = CW'(col_ff + CW'(1));
               end else begin
                  col_in = '0;
                  if (row_ff != row_max) begin
                     row_in = RW'(row_ff + RW'(1));
                  end else begin
                     row_in  = '0;
                     mode_in = bcae_pkg::MODE_PLAN;
                     src_in  = ~src_ff;
                     if (op_ff == bcae_pkg::OP_SHIFT) begin
                        frame_in = 1'b1;
                     end else if (op_ff == bcae_pkg::OP_UNSHIFT) begin
                        frame_in = 1'b0;
                     end
                     if (rule_on_ff) begin
                        gens_in  = gens_ff - 16'd1;
                        phase_in = ~phase_ff;
                     end
                  end
               end
            end
         end
         bcae_pkg::MODE_EMIT: begin
            if (!pend_ff && (!rsp_valid_ff || !rsp_stall)) begin
               emit_rd = 1'b1;
               emit_in = NW'(emit_ff + NW'(1));
               if (emit_ff == n_last) begin
                  mode_in   = bcae_pkg::MODE_LOAD;
                  loaded_in = '0;
               end
            end
         end
         default: begin
            mode_in = bcae_pkg::MODE_LOAD;
         end
      endcase
   end

   always_comb begin
      pend_in      = emit_rd;
      pend_last_in = emit_rd && (emit_ff == n_last);
      rsp_valid_in = rsp_valid_ff;
      if (pend_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= bcae_pkg::MODE_LOAD;
         op_ff        <= bcae_pkg::OP_LOCAL;
         loaded_ff    <= '0;
         gens_ff      <= '0;
         phase_ff     <= 1'b0;
         frame_ff     <= 1'b0;
         src_ff       <= 1'b0;
         rule_on_ff   <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         step_ff      <= '0;
         emit_ff      <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         op_ff        <= op_in;
         loaded_ff    <= loaded_in;
         gens_ff      <= gens_in;
         phase_ff     <= phase_in;
         frame_ff     <= frame_in;
         src_ff       <= src_in;
         rule_on_ff   <= rule_on_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         step_ff      <= step_in;
         emit_ff      <= emit_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         rsp_tile_ff <= rda_ff;
         rsp_last_ff <= pend_last_ff;
      end
      if (mode_ff == bcae_pkg::MODE_PASS && step_ff inside {[3'd1:3'd4]}) begin
         nb_ff[2'(step_ff - 3'd1)] <= src_ff ? rdb_ff : rda_ff;
      end
   end

   // memory a holds the grid between runs; passes ping-pong between a and b
   assign rd_addr = (mode_ff == bcae_pkg::MODE_EMIT) ? emit_ff[AW-1:0] : pass_addr;
   assign wa_en   = load_we || (pass_we && src_ff);
   assign wb_en   = pass_we && !src_ff;
   assign wa_addr = load_we ? loaded_ff[AW-1:0] : own_addr;
   assign wa_data = load_we ? req_tile_in : new_tile;

   always_ff @(posedge clock) begin
      if (wa_en) begin
         mem_a[wa_addr] <= wa_data;
      end
      rda_ff <= mem_a[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wb_en) begin
         mem_b[own_addr] <= new_tile;
      end
      rdb_ff <= mem_b[rd_addr];
   end

   assign req_stall         = (mode_ff != bcae_pkg::MODE_LOAD);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tile_out      = rsp_tile_ff;
   assign rsp_tile_out_last = rsp_last_ff;

endmodule

/* rtl/bcae_checker.sv */
module bcae_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_tile_in_last,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [bcae_pkg::TILE_W-1:0]         rsp_tile_out,
   input logic                                rsp_tile_out_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tile_out))
      else $error("stalled result changed");

   a_run_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_tile_in_last |=> req_stall)
      else $error("engine took input right after the last tile");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_tile_out_last |=> !rsp_valid)
      else $error("result after the last tile of the grid");

   a_emit_blocks_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tile_out_last |-> req_stall)
      else $error("input accepted while the grid is still being emitted");

endmodule

bind block_cellular_automaton_engine_top bcae_checker u_bcae_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_tile_in_last  (req_tile_in_last),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_tile_out      (rsp_tile_out),
   .rsp_tile_out_last (rsp_tile_out_last)
);

/* dv/block_cellular_automaton_engine_top_test.sv */
module block_cellular_automaton_engine_top_test;

   typedef struct {
      logic [bcae_pkg::TILE_W-1:0] tile;
      logic                        last;
   } tile_result_type;

   class margolus_scoreboard;
      logic [bcae_pkg::TILE_W-1:0] rule;
      logic [3:0]                  width_reg;
      logic [3:0]                  height_reg;
      logic                        first_odd;
      logic [bcae_pkg::GEN_W-1:0]  gen_count;
      logic [bcae_pkg::TILE_W-1:0] front [64];
      logic [bcae_pkg::TILE_W-1:0] back [64];
      int                          loaded;
      tile_result_type             pending_tiles [$];
      int                          errors;

      function void reset_state();
         rule = '0;
         width_reg = 4'd8;
         height_reg = 4'd8;
         first_odd = 1'b0;
         gen_count = 16'd1;
         loaded = 0;
         errors = 0;
         foreach (front[i]) begin
            front[i] = '0;
            back[i] = '0;
         end
      endfunction

      function void write_reg(logic [bcae_pkg::CSR_INDEX_W-1:0] idx,
                              logic [bcae_pkg::TILE_W-1:0] value);
         case (idx)
            bcae_pkg::CSR_RULE_TABLE:  rule = value;
            bcae_pkg::CSR_GRID_WIDTH:  width_reg = value[3:0];
            bcae_pkg::CSR_GRID_HEIGHT: height_reg = value[3:0];
            bcae_pkg::CSR_FIRST_ODD:   first_odd = value[0];
            bcae_pkg::CSR_GEN_COUNT:   gen_count = value[bcae_pkg::GEN_W-1:0];
            default: ;
         endcase
      endfunction

      function int dim(logic [3:0] v);
         if (v == 0) return 1;
         if (v > 8) return 8;
         return v;
      endfunction

      function logic get_cell(int w, int y, int x);
         return front[(y >> 3) * w + (x >> 3)][((y & 7) << 3) | (x & 7)];
      endfunction

      function void put(int w, int y, int x, logic v);
         back[(y >> 3) * w + (x >> 3)][((y & 7) << 3) | (x & 7)] = v;
      endfunction

      function void evolve(int w, int h, logic odd);
         int rows;
         int cols;
         int off;
         int y0;
         int y1;
         int x0;
         int x1;
         logic [3:0] idx;
         logic [3:0] res;
         rows = h * 8;
         cols = w * 8;
         off = odd ? 1 : 0;
         for (int i = 0; i < w * h; i++) back[i] = '0;
         for (int r = 0; r < rows / 2; r++) begin
            y0 = (2 * r + rows - off) % rows;
            y1 = (y0 + 1) % rows;
            for (int c = 0; c < cols / 2; c++) begin
               x0 = (2 * c + cols - off) % cols;
               x1 = (x0 + 1) % cols;
               idx = {get_cell(w, y1, x1), get_cell(w, y1, x0),
                      get_cell(w, y0, x1), get_cell(w, y0, x0)};
               res = rule[idx*4 +: 4];
               put(w, y0, x0, res[0]);
               put(w, y0, x1, res[1]);
               put(w, y1, x0, res[2]);
               put(w, y1, x1, res[3]);
            end
         end
         for (int i = 0; i < w * h; i++) front[i] = back[i];
      endfunction

      function void note_tile(logic [bcae_pkg::TILE_W-1:0] tile, logic last);
         int w;
         int h;
         int n;
         logic odd;
         tile_result_type res;
         w = dim(width_reg);
         h = dim(height_reg);
         n = w * h;
         if (loaded < n) begin
            front[loaded] = tile;
            loaded++;
         end
         if (!last) return;
         odd = first_odd;
         for (int g = 0; g < gen_count; g++) begin
            evolve(w, h, odd);
            odd = ~odd;
         end
         for (int i = 0; i < n; i++) begin
            res.tile = front[i];
            res.last = (i + 1 == n);
            pending_tiles.push_back(res);
         end
         loaded = 0;
      endfunction

      function void check_tile(logic [bcae_pkg::TILE_W-1:0] tile, logic last);
         tile_result_type want;
         if (pending_tiles.size() == 0) begin
            $error("unexpected tile %h", tile);
            errors++;
            return;
         end
         want = pending_tiles.pop_front();
         if (tile !== want.tile) begin
            $error("tile_out expected %h actual %h", want.tile, tile);
            errors++;
         end
         if (last !== want.last) begin
            $error("tile_out_last expected %b actual %b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [bcae_pkg::TILE_W-1:0]      req_tile_in;
   logic                             req_tile_in_last;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [bcae_pkg::TILE_W-1:0]      rsp_tile_out;
   logic                             rsp_tile_out_last;
   logic                             csr_write;
   logic [bcae_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [bcae_pkg::TILE_W-1:0]      csr_data;

   margolus_scoreboard sb;
   bit   calm;
   bit   hold_rsp;
   int   quiet_cycles;
   bit   written [64];
   int   tiles_sent;

   block_cellular_automaton_engine_top DUT (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 22);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_tile(rsp_tile_out, rsp_tile_out_last);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles > 4000000) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      wait (hold_rsp);
      repeat (2000) @(negedge clock);
      hold_rsp = 1'b0;
   end

   task automatic write_csr(logic [bcae_pkg::CSR_INDEX_W-1:0] idx,
                            logic [bcae_pkg::TILE_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic send_tile(logic [bcae_pkg::TILE_W-1:0] tile, logic last);
      @(negedge clock);
      if (!calm && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < 50);
      end
      req_valid <= 1'b1;
      req_tile_in <= tile;
      req_tile_in_last <= last;
      do @(posedge clock); while (req_stall);
      sb.note_tile(tile, last);
      tiles_sent++;
   endtask

   function automatic logic [bcae_pkg::TILE_W-1:0] random_tile();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // count < n gives a short load, count > n sends extra tiles that get dropped
   task automatic load_grid(int count);
      int n;
      n = sb.dim(sb.width_reg) * sb.dim(sb.height_reg);
      for (int i = 0; i < count; i++) begin
         send_tile(random_tile(), i == count - 1);
         if (i < n) written[i] = 1'b1;
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_tiles.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_grid(int w, int h, logic odd, int gens);
      write_csr(bcae_pkg::CSR_GRID_WIDTH, 64'(w));
      write_csr(bcae_pkg::CSR_GRID_HEIGHT, 64'(h));
      write_csr(bcae_pkg::CSR_FIRST_ODD, 64'(odd));
      write_csr(bcae_pkg::CSR_GEN_COUNT, 64'(gens));
   endtask

   initial begin
      int n;
      int count;
      bit full;
      sb = new();
      sb.reset_state();
      reset = 1'b1;
      req_valid = 1'b0;
      req_tile_in = '0;
      req_tile_in_last = 1'b0;
      rsp_stall = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      calm = 1'b0;
      hold_rsp = 1'b0;
      quiet_cycles = 0;
      tiles_sent = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // identity rule, unchanged grid with zero generations
      write_csr(bcae_pkg::CSR_RULE_TABLE, 64'hFEDCBA9876543210);
      set_grid(1, 1, 1'b1, 0);
      load_grid(1);
      settle();
      write_csr(bcae_pkg::CSR_GEN_COUNT, 64'd1);
      write_csr(bcae_pkg::CSR_FIRST_ODD, 64'd0);
      send_tile('1, 1'b1);
      settle();
      write_csr(bcae_pkg::CSR_RULE_TABLE, {$urandom, $urandom});
      set_grid(0, 2, 1'b1, 2);
      load_grid(4);
      settle();
      set_grid(15, 1, 1'b0, 3);
      load_grid(8);
      settle();
      write_csr(bcae_pkg::CSR_RULE_TABLE, '1);
      set_grid(2, 0, 1'b1, 1);
      send_tile('0, 1'b0);
      send_tile('1, 1'b1);
      settle();
      write_csr(3'd5, '1);
      write_csr(3'd7, '0);
      set_grid(1, 2, 1'b0, 1);
      load_grid(1);
      settle();
      write_csr(bcae_pkg::CSR_RULE_TABLE, {$urandom, $urandom});
      set_grid(1, 1, 1'b0, 65535);
      load_grid(1);
      settle();

      // full 8x8 grid under the back-pressure hold, two grids back to back
      set_grid(8, 15, 1'b1, 1);
      hold_rsp = 1'b1;
      load_grid(64);
      load_grid(64);
      settle();

      while (tiles_sent < 170) begin
         write_csr(bcae_pkg::CSR_RULE_TABLE, {$urandom, $urandom});
         if ($urandom_range(9) == 0) begin
            set_grid($urandom_range(15), $urandom_range(15), $urandom_range(1),
                     $urandom_range(3));
         end else begin
            set_grid($urandom_range(3), $urandom_range(3), $urandom_range(1),
                     $urandom_range(5));
         end
         calm = ($urandom_range(7) == 0);
         n = sb.dim(sb.width_reg) * sb.dim(sb.height_reg);
         full = 1'b1;
         for (int i = 0; i < n; i++) if (!written[i]) full = 1'b0;
         case ($urandom_range(9))
            0: count = n + $urandom_range(1, 4);
            1: count = full ? $urandom_range(1, n) : n;
            default: count = n;
         endcase
         load_grid(count);
         settle();
         calm = 1'b0;
      end

      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
